// File: hdl/tscr_pkg.sv
// shared constants for the text and block-graphics cell renderer
// used by the renderer, port checker and testbench; no dependencies
package tscr_pkg;

    localparam int CELL_ROWS   = 8;
    localparam int GLYPH_COUNT = 128;
    localparam int STORE_DEPTH = CELL_ROWS * GLYPH_COUNT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = $clog2(CELL_ROWS);
    localparam int CODE_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int PIX_W       = 3;
    localparam int PIX_COUNT   = 6;

    // input item packing
    localparam int S_DATA_W    = 32;
    localparam int S_USED_W    = ADDR_W + BYTE_W + CODE_W + ROW_W;
    // result item packing
    localparam int M_DATA_W    = 24;
    localparam int M_USED_W    = PIX_W * PIX_COUNT;

    // item kinds carried on s_tuser
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    // cell code bit positions
    localparam int BLOCK_BIT   = 7;
    localparam int INVERT_BIT  = 6;
    localparam int KEEP_BIT    = 5;
    localparam int GREY_LSB    = 4;
    localparam int TOP_LEFT    = 0;
    localparam int TOP_RIGHT   = 1;
    localparam int BOT_LEFT    = 2;
    localparam int BOT_RIGHT   = 3;

    localparam logic [PIX_W-1:0] PIX_ON  = 3'd7;
    localparam logic [PIX_W-1:0] PIX_OFF = 3'd0;

endpackage

// File: hdl/text_semigraphic_cell_renderer.sv
// top level of the text and block-graphics cell renderer
// depends on tscr_pkg for constants and item packing
//
// One render item gives one result item: the six grey pixels of one scan row
// of one character cell. Load items write one byte of the 1024-entry glyph
// store and give no result. The block takes one item per clock while s_tready
// is high and holds three register stages: decode and glyph address, glyph
// store read (read data registered), pixel formation into the output register.
// A render result passes the decode, read and output registers on its way to
// m_tvalid and can leave at the next edge when the output side does not stall.
// Each stage advances on its own, so bubbles close up and new items still come
// in while a finished result waits for m_tready, until the decode and read
// stages fill. A render sees every load accepted before it. The glyph store
// has no reset; rendering a never-loaded entry gives undefined pixels.
module text_semigraphic_cell_renderer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // glyph_address[9:0], glyph_byte[17:10], cell_code[25:18], cell_row[28:26], zeros
    input  logic [tscr_pkg::S_DATA_W-1:0] s_tdata,
    // req_type
    input  logic                          s_tuser,
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_a[2:0], pixel_b[5:3], pixel_c[8:6], pixel_d[11:9], pixel_e[14:12],
    // pixel_f[17:15], zeros
    output logic [tscr_pkg::M_DATA_W-1:0] m_tdata
);
    import tscr_pkg::*;

    // unpacked input fields
    logic [ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0] in_byte;
    logic [CODE_W-1:0] in_code;
    logic [ROW_W-1:0]  in_row;

    assign in_addr = s_tdata[ADDR_W-1:0];
    assign in_byte = s_tdata[ADDR_W +: BYTE_W];
    assign in_code = s_tdata[ADDR_W+BYTE_W +: CODE_W];
    assign in_row  = s_tdata[ADDR_W+BYTE_W+CODE_W +: ROW_W];

    // stage enables, each stage moves when its successor can take it
    logic en1, en2, en3;

    // stage 1: decoded item
    logic              v1_reg, v1_next;
    logic              load1_reg;
    logic [ADDR_W-1:0] waddr1_reg;
    logic [BYTE_W-1:0] wbyte1_reg;
    logic [ADDR_W-1:0] raddr1_reg;
    logic              blk1_reg;
    logic [PIX_W-1:0]  left1_reg, right1_reg;

    // stage 2: glyph read data beside the block-graphics levels
    logic              v2_reg, v2_next;
    logic              blk2_reg;
    logic [PIX_W-1:0]  left2_reg, right2_reg;
    logic [BYTE_W-1:0] glyph2_reg;

    // stage 3: output register
    logic                v3_reg, v3_next;
    logic [M_USED_W-1:0] pix3_reg, pix3_next;

    // glyph store
    logic [BYTE_W-1:0] glyph_mem [STORE_DEPTH];

    // decode of the incoming item
    logic [CODE_W-1:0] text_code;
    logic              top_half;
    logic [PIX_W-1:0]  grey;
    logic              lit_left, lit_right;
    logic [ADDR_W-1:0] raddr_next;

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_comb begin
        // text codes with bit 5 clear get bit 6 flipped
        text_code = in_code;
        if (!in_code[KEEP_BIT]) begin
            text_code[INVERT_BIT] = !in_code[INVERT_BIT];
        end
        raddr_next = {text_code[INVERT_BIT:0], in_row};
        top_half   = !in_row[ROW_W-1];
        grey       = in_code[GREY_LSB +: PIX_W];
        lit_left   = top_half ? in_code[TOP_LEFT]  : in_code[BOT_LEFT];
        lit_right  = top_half ? in_code[TOP_RIGHT] : in_code[BOT_RIGHT];
    end

    assign v1_next = s_tvalid;
    // loads stop after stage 1, only renders travel on
    assign v2_next = v1_reg && (load1_reg == REQ_RENDER);
    assign v3_next = v2_reg;

    // pixel formation, pixel_a in the lowest bits
    always_comb begin
        for (int k = 0; k < PIX_COUNT; k++) begin
            if (blk2_reg) begin
                pix3_next[k*PIX_W +: PIX_W] = (k < PIX_COUNT/2) ? left2_reg : right2_reg;
            end else begin
                pix3_next[k*PIX_W +: PIX_W] = glyph2_reg[PIX_COUNT-1-k] ? PIX_ON : PIX_OFF;
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= v1_next;
            end
            if (en2) begin
                v2_reg <= v2_next;
            end
            if (en3) begin
                v3_reg <= v3_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en1) begin
            load1_reg  <= s_tuser;
            waddr1_reg <= in_addr;
            wbyte1_reg <= in_byte;
            raddr1_reg <= raddr_next;
            blk1_reg   <= in_code[BLOCK_BIT];
            left1_reg  <= lit_left  ? grey : PIX_OFF;
            right1_reg <= lit_right ? grey : PIX_OFF;
        end
        if (en2) begin
            blk2_reg   <= blk1_reg;
            left2_reg  <= left1_reg;
            right2_reg <= right1_reg;
        end
        if (en3) begin
            pix3_reg <= pix3_next;
        end
    end

    // glyph store: the load writes as it leaves stage 1, a render reads
    // as it leaves stage 1, so a later render always sees an earlier load
    always_ff @(posedge aclk) begin
        if (en2 && v1_reg && (load1_reg == REQ_LOAD)) begin
            glyph_mem[waddr1_reg] <= wbyte1_reg;
        end
        if (en2) begin
            glyph2_reg <= glyph_mem[raddr1_reg];
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(M_DATA_W-M_USED_W){1'b0}}, pix3_reg};

endmodule

// File: hdl/tscr_checker.sv
// port checker for the cell renderer and its bind to the top level
// depends on tscr_pkg and text_semigraphic_cell_renderer
module tscr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tscr_pkg::M_DATA_W-1:0] m_tdata
);
    import tscr_pkg::*;

    logic [PIX_W-1:0] pa, pb, pc, pd, pe, pf;
    logic             halves_flat, all_binary;

    assign pa = m_tdata[0*PIX_W +: PIX_W];
    assign pb = m_tdata[1*PIX_W +: PIX_W];
    assign pc = m_tdata[2*PIX_W +: PIX_W];
    assign pd = m_tdata[3*PIX_W +: PIX_W];
    assign pe = m_tdata[4*PIX_W +: PIX_W];
    assign pf = m_tdata[5*PIX_W +: PIX_W];

    assign halves_flat = (pa == pb) && (pb == pc) && (pd == pe) && (pe == pf);
    assign all_binary  = ((pa == PIX_ON) || (pa == PIX_OFF)) && ((pb == PIX_ON) || (pb == PIX_OFF))
                      && ((pc == PIX_ON) || (pc == PIX_OFF)) && ((pd == PIX_ON) || (pd == PIX_OFF))
                      && ((pe == PIX_ON) || (pe == PIX_OFF)) && ((pf == PIX_ON) || (pf == PIX_OFF));

    // a result held by the sink stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item valid after reset");

    // an open output side never blocks the input
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled with output ready");

    // a row is either two flat halves or a text row of on and off pixels
    a_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> halves_flat || all_binary)
        else $error("pixel row is neither block nor text shaped");

    // padding stays zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:M_USED_W] == '0)
        else $error("padding bits set in result item");

endmodule

bind text_semigraphic_cell_renderer tscr_checker u_tscr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/tb.sv
// testbench for the text and block-graphics cell renderer: directed rows, then random traffic
// depends on tscr_pkg and text_semigraphic_cell_renderer; results checked by a local pixel predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tscr_pkg::*;

    localparam int ITEM_COUNT = 900;
    localparam int DRAIN_WAIT = 10;   // drain margin past the three-stage pipe

    typedef logic [M_USED_W-1:0] pixel_row_t;   // pixel_a in the lowest bits

    // what the sender knows about an item when it offers it
    typedef struct {
        bit         typed;   // expected row typed into the directed table
        pixel_row_t pix;
    } item_note_t;

    // one row of the directed table
    typedef struct {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] gbyte;
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  row;
        bit                typed;
        pixel_row_t        pix;
    } dir_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = REQ_LOAD;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // glyph contents as the block should hold them, updated on accepted loads
    logic [BYTE_W-1:0] glyph_shadow [STORE_DEPTH];
    // entries the sender has already loaded; a text render never reads any other
    bit                glyph_loaded [STORE_DEPTH];

    item_note_t note_q [$];
    pixel_row_t pixel_row_q [$];     // rows still owed by the block, oldest first
    dir_row_t   directed_rows [$];

    bit calm = 1'b0;                 // both sides run without gaps while set
    int fails = 0;
    int loads_sent = 0;
    int renders_sent = 0;
    int rows_checked = 0;

    string pix_name [PIX_COUNT] = '{"pixel_a", "pixel_b", "pixel_c",
                                    "pixel_d", "pixel_e", "pixel_f"};

    text_semigraphic_cell_renderer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // pack six grey levels, leftmost pixel first
    function automatic pixel_row_t pack6(input int a, b, c, d, e, f);
        return {f[2:0], e[2:0], d[2:0], c[2:0], b[2:0], a[2:0]};
    endfunction

    // glyph entry a text code reads: bit 6 flips when bit 5 is clear
    function automatic logic [ADDR_W-1:0] glyph_index(input logic [CODE_W-1:0] code,
                                                      input logic [ROW_W-1:0] row);
        logic [CODE_W-1:0] c;
        c = code;
        if (!c[KEEP_BIT])
            c[INVERT_BIT] = ~c[INVERT_BIT];
        return {c[6:0], row};
    endfunction

    // expected pixels of one cell row from the current glyph contents
    function automatic pixel_row_t predict_pixels(input logic [CODE_W-1:0] code,
                                                  input logic [ROW_W-1:0] row);
        logic [PIX_W-1:0]  grey;
        logic [PIX_W-1:0]  left;
        logic [PIX_W-1:0]  right;
        logic [BYTE_W-1:0] pat;
        pixel_row_t        pix;
        if (code[BLOCK_BIT]) begin
            // 2x2 block cell: one quadrant bit per half, top rows use bits 0/1
            grey  = code[GREY_LSB +: PIX_W];
            left  = code[(row < 4) ? TOP_LEFT : BOT_LEFT] ? grey : PIX_OFF;
            right = code[(row < 4) ? TOP_RIGHT : BOT_RIGHT] ? grey : PIX_OFF;
            pix   = {right, right, right, left, left, left};
        end else begin
            // glyph bit 5 is the leftmost pixel, bits 7 and 6 play no part
            pat = glyph_shadow[glyph_index(code, row)];
            for (int k = 0; k < PIX_COUNT; k++)
                pix[k*PIX_W +: PIX_W] = pat[5-k] ? PIX_ON : PIX_OFF;
        end
        return pix;
    endfunction

    function automatic dir_row_t load_row(input int addr, gbyte, code, row);
        dir_row_t r;
        r.kind  = REQ_LOAD;
        r.addr  = ADDR_W'(addr);
        r.gbyte = BYTE_W'(gbyte);
        r.code  = CODE_W'(code);
        r.row   = ROW_W'(row);
        r.typed = 1'b0;
        r.pix   = '0;
        return r;
    endfunction

    function automatic dir_row_t render_row(input int code, row, bit typed, pixel_row_t pix);
        dir_row_t r;
        r.kind  = REQ_RENDER;
        r.addr  = ADDR_W'($urandom_range(0, STORE_DEPTH - 1));   // ignored on a render
        r.gbyte = BYTE_W'($urandom_range(0, 255));
        r.code  = CODE_W'(code);
        r.row   = ROW_W'(row);
        r.typed = typed;
        r.pix   = pix;
        return r;
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] gbyte, input logic [CODE_W-1:0] code,
                             input logic [ROW_W-1:0] row, input bit typed, input pixel_row_t pix);
        item_note_t note;
        // random gaps on the input side, about a third of the cycles
        while (!calm && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        note.typed = typed;
        note.pix   = pix;
        note_q.push_back(note);
        if (kind == REQ_LOAD) begin
            glyph_loaded[addr] = 1'b1;
            loads_sent++;
        end else begin
            renders_sent++;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_DATA_W - S_USED_W){1'b0}}, row, code, gbyte, addr};
        do @(posedge aclk); while (!s_tready);
    endtask

    // observer: predicts on accepted items, checks accepted results, drives m_tready
    always @(posedge aclk) begin : watch
        item_note_t note;
        pixel_row_t want;
        pixel_row_t got;
        if (aresetn) begin
            // the input side is handled first, so a load lands before any later render
            if (s_tvalid && s_tready) begin
                note = note_q.pop_front();
                if (s_tuser == REQ_LOAD)
                    glyph_shadow[s_tdata[0 +: ADDR_W]] = s_tdata[ADDR_W +: BYTE_W];
                else if (note.typed)
                    pixel_row_q.push_back(note.pix);
                else
                    pixel_row_q.push_back(predict_pixels(s_tdata[ADDR_W+BYTE_W +: CODE_W],
                                                         s_tdata[ADDR_W+BYTE_W+CODE_W +: ROW_W]));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[M_USED_W-1:0];
                if (pixel_row_q.size() == 0) begin
                    $error("result item with no render pending: %h", got);
                    fails++;
                end else begin
                    want = pixel_row_q.pop_front();
                    rows_checked++;
                    for (int k = 0; k < PIX_COUNT; k++) begin
                        if (got[k*PIX_W +: PIX_W] !== want[k*PIX_W +: PIX_W]) begin
                            $error("%s: expected %0d, actual %0d", pix_name[k],
                                   want[k*PIX_W +: PIX_W], got[k*PIX_W +: PIX_W]);
                            fails++;
                        end
                    end
                end
            end
        end
        // output stalls about a third of the cycles, none during the calm stretch
        m_tready <= calm || ($urandom_range(0, 99) >= 33);
    end

    initial begin : stim
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] idx;
        int                pick;

        // text codes: bit 5 clear flips bit 6 before the glyph lookup
        directed_rows.push_back(load_row(0, 8'h3F, 8'h00, 0));       // lowest entry
        directed_rows.push_back(render_row(8'h40, 0, 1, pack6(7, 7, 7, 7, 7, 7)));
        directed_rows.push_back(load_row(1023, 8'hFF, 8'hFF, 7));    // highest entry
        directed_rows.push_back(render_row(8'h7F, 7, 1, pack6(7, 7, 7, 7, 7, 7)));
        directed_rows.push_back(load_row(256, 8'h2A, 8'h00, 0));
        directed_rows.push_back(render_row(8'h20, 0, 1, pack6(7, 0, 7, 0, 7, 0)));
        // only glyph bits 7 and 6 set: nothing lit
        directed_rows.push_back(load_row(515, 8'hC0, 8'h55, 2));
        directed_rows.push_back(render_row(8'h00, 3, 1, pack6(0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(load_row(253, 8'h15, 8'hAA, 5));
        directed_rows.push_back(render_row(8'h5F, 5, 1, pack6(0, 7, 0, 7, 0, 7)));
        directed_rows.push_back(load_row(768, 8'h00, 8'hFF, 7));     // all-zero byte
        directed_rows.push_back(render_row(8'h60, 0, 1, pack6(0, 0, 0, 0, 0, 0)));
        // load with every render field at its top value
        directed_rows.push_back(load_row(5, 8'h21, 8'hFF, 7));
        directed_rows.push_back(render_row(8'h40, 5, 1, pack6(7, 0, 0, 0, 0, 7)));
        // block cells: each quadrant, top and bottom row extremes, grey levels
        directed_rows.push_back(render_row(8'hFF, 0, 1, pack6(7, 7, 7, 7, 7, 7)));
        directed_rows.push_back(render_row(8'hFF, 7, 1, pack6(7, 7, 7, 7, 7, 7)));
        directed_rows.push_back(render_row(8'h80, 3, 1, pack6(0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(render_row(8'hF1, 3, 1, pack6(7, 7, 7, 0, 0, 0)));
        directed_rows.push_back(render_row(8'hF2, 0, 1, pack6(0, 0, 0, 7, 7, 7)));
        directed_rows.push_back(render_row(8'hF4, 4, 1, pack6(7, 7, 7, 0, 0, 0)));
        directed_rows.push_back(render_row(8'hF8, 7, 1, pack6(0, 0, 0, 7, 7, 7)));
        directed_rows.push_back(render_row(8'hB3, 2, 1, pack6(3, 3, 3, 3, 3, 3)));
        directed_rows.push_back(render_row(8'h9C, 3, 1, pack6(0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(render_row(8'h9C, 6, 1, pack6(1, 1, 1, 1, 1, 1)));
        directed_rows.push_back(render_row(8'h8F, 1, 1, pack6(0, 0, 0, 0, 0, 0)));  // grey zero
        directed_rows.push_back(render_row(8'hD5, 4, 0, '0));        // predictor only

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].gbyte,
                      directed_rows[i].code, directed_rows[i].row, directed_rows[i].typed,
                      directed_rows[i].pix);

        // random traffic: a third loads, the rest split between block and text cells;
        // a text cell whose glyph entry is still empty gets that entry loaded first
        for (int n = 0; n < ITEM_COUNT; n++) begin
            calm = (n >= 300 && n < 500);
            pick = int'($urandom_range(0, 99));
            row  = ROW_W'($urandom_range(0, CELL_ROWS - 1));
            code = CODE_W'($urandom_range(0, 255));
            if (pick < 33) begin
                send_item(REQ_LOAD, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
                          BYTE_W'($urandom_range(0, 255)), code, row, 1'b0, '0);
            end else if (pick < 66) begin
                code[BLOCK_BIT] = 1'b1;
                send_item(REQ_RENDER, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
                          BYTE_W'($urandom_range(0, 255)), code, row, 1'b0, '0);
            end else begin
                code[BLOCK_BIT] = 1'b0;
                idx = glyph_index(code, row);
                if (!glyph_loaded[idx]) begin
                    send_item(REQ_LOAD, idx, BYTE_W'($urandom_range(0, 255)),
                              CODE_W'($urandom_range(0, 255)),
                              ROW_W'($urandom_range(0, CELL_ROWS - 1)), 1'b0, '0);
                    n++;   // the extra load counts toward the item budget
                end
                send_item(REQ_RENDER, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
                          BYTE_W'($urandom_range(0, 255)), code, row, 1'b0, '0);
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // drain: every render must have come back, then watch a little longer for strays
        while (pixel_row_q.size() != 0 || note_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d glyph loads and %0d cell renders, %0d result rows compared",
                 loads_sent, renders_sent, rows_checked);
        $display("random gaps on both sides, with one stretch of back-to-back traffic");
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/tscr_pkg.sv
hdl/text_semigraphic_cell_renderer.sv
hdl/tscr_checker.sv
dv/tb.sv
